FILE: sv/cu_pkg.sv
// shared types and constants for the combination unrank block
`timescale 1ns / 1ps
package cu_pkg;
    localparam int VAL_W       = 64;
    localparam int CNT_W       = $clog2(VAL_W);
    localparam int RANK_W      = 30;
    localparam int SIZE_W      = 6;
    localparam int ELEM_W      = 5;
    localparam int MAX_SET_DEF = 32;
    localparam int MAX_RES     = 32;
    localparam int QDEPTH      = 2;

    typedef struct packed {
        logic [SIZE_W-1:0] m;
        logic [SIZE_W-1:0] n;
        logic [RANK_W-1:0] rank;
        logic              bad;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_WALK,
        S_ERR
    } t_state;

    typedef enum logic [1:0] {
        PH_BIN,
        PH_FIRST,
        PH_WALK
    } t_phase;
endpackage

FILE: sv/cu_if.sv
// item channels of the combination unrank block
`timescale 1ns / 1ps
interface cu_in_if;
    logic                      valid;
    logic                      ready;
    logic [cu_pkg::SIZE_W-1:0] set_size;
    logic [cu_pkg::SIZE_W-1:0] subset_size;
    logic [cu_pkg::RANK_W-1:0] rank;
    modport source (output valid, set_size, subset_size, rank, input ready);
    modport sink (input valid, set_size, subset_size, rank, output ready);
endinterface

interface cu_out_if;
    logic                      valid;
    logic                      ready;
    logic [cu_pkg::ELEM_W-1:0] element;
    logic                      last;
    logic                      bad_args;
    modport source (output valid, element, last, bad_args, input ready);
    modport sink (input valid, element, last, bad_args, output ready);
endinterface

FILE: sv/cu_front.sv
// front stage: takes items and flags argument errors
`timescale 1ns / 1ps
module cu_front #(
    parameter int MAX_SET = cu_pkg::MAX_SET_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cu_in_if.sink        i_in,
    output logic         o_valid,
    output cu_pkg::t_job o_job,
    input  logic         i_ready
);
    logic         r_v;
    cu_pkg::t_job r_job;
    logic         w_bad;

    assign i_in.ready = !r_v || i_ready;

    // range checks; rank against the count is done in the back
    assign w_bad = (i_in.subset_size == '0)
                || (i_in.subset_size > i_in.set_size)
                || (i_in.set_size > cu_pkg::SIZE_W'(MAX_SET))
                || (i_in.subset_size > cu_pkg::SIZE_W'(cu_pkg::MAX_RES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_in.ready) begin
            r_v <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_job.m    <= i_in.set_size;
            r_job.n    <= i_in.subset_size;
            r_job.rank <= i_in.rank;
            r_job.bad  <= w_bad;
        end
    end

    assign o_valid = r_v;
    assign o_job   = r_job;
endmodule

FILE: sv/cu_queue.sv
// short queue between front and back
`timescale 1ns / 1ps
module cu_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  cu_pkg::t_job i_job,
    output logic         o_ready,
    output logic         o_valid,
    output cu_pkg::t_job o_job,
    input  logic         i_ready
);
    localparam int PW = $clog2(cu_pkg::QDEPTH);

    cu_pkg::t_job r_mem [cu_pkg::QDEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_cnt != (PW+1)'(cu_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(w_push) - (PW+1)'(w_pop);
        end
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

FILE: sv/cu_back.sv
// back engine: binomial count, rank check and element walk
`timescale 1ns / 1ps
module cu_back (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  cu_pkg::t_job i_job,
    output logic         o_ready,
    cu_out_if.source     o_out
);
    localparam int VW = cu_pkg::VAL_W;
    localparam int SW = cu_pkg::SIZE_W;

    cu_pkg::t_state r_state, n_state;
    cu_pkg::t_phase r_phase, n_phase;
    logic [SW-1:0]  r_m, n_m;
    logic [SW-1:0]  r_n, n_n;
    logic [SW-1:0]  r_b, n_b;
    logic [SW-1:0]  r_k, n_k;
    logic [SW-1:0]  r_j, n_j;
    logic [SW-1:0]  r_a, n_a;
    logic [SW-1:0]  r_left, n_left;
    logic [SW-1:0]  r_mult, n_mult;
    logic [SW-1:0]  r_dvsr, n_dvsr;
    logic [cu_pkg::RANK_W-1:0] r_rank, n_rank;
    logic [VW-1:0]  r_acc, n_acc;
    logic [VW-1:0]  r_quo, n_quo;
    logic [SW:0]    r_rem, n_rem;
    logic [cu_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic           r_ov, n_ov;
    logic [cu_pkg::ELEM_W-1:0] r_elem, n_elem;
    logic           r_last, n_last;
    logic           r_bad, n_bad;

    logic           w_free;
    logic           w_take;
    logic           w_div_end;
    logic [SW:0]    w_trial;
    logic [SW-1:0]  w_nb;

    assign w_free    = !r_ov || o_out.ready;
    assign w_take    = ({{(VW-cu_pkg::RANK_W){1'b0}}, r_rank} < r_acc);
    assign w_div_end = (r_cnt == cu_pkg::CNT_W'(VW-1));
    assign w_trial   = {r_rem[SW-1:0], r_quo[VW-1]};
    assign w_nb      = (i_job.n > i_job.m - i_job.n) ? (i_job.m - i_job.n) : i_job.n;
    assign o_ready   = (r_state == cu_pkg::S_IDLE);

    assign o_out.valid    = r_ov;
    assign o_out.element  = r_elem;
    assign o_out.last     = r_last;
    assign o_out.bad_args = r_bad;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cu_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (i_job.bad) begin
                        n_state = cu_pkg::S_ERR;
                    end else if (w_nb == '0) begin
                        n_state = cu_pkg::S_CHECK;
                    end else begin
                        n_state = cu_pkg::S_MUL;
                    end
                end
            end
            cu_pkg::S_CHECK: begin
                n_state = w_take ? cu_pkg::S_MUL : cu_pkg::S_ERR;
            end
            cu_pkg::S_MUL: begin
                n_state = cu_pkg::S_DIV;
            end
            cu_pkg::S_DIV: begin
                if (w_div_end) begin
                    if (r_phase == cu_pkg::PH_BIN && r_k == r_b) begin
                        n_state = cu_pkg::S_CHECK;
                    end else if (r_phase == cu_pkg::PH_BIN) begin
                        n_state = cu_pkg::S_MUL;
                    end else begin
                        n_state = cu_pkg::S_WALK;
                    end
                end
            end
            cu_pkg::S_WALK: begin
                if (!w_take) begin
                    n_state = cu_pkg::S_MUL;
                end else if (w_free) begin
                    n_state = (r_left == SW'(1)) ? cu_pkg::S_IDLE : cu_pkg::S_MUL;
                end
            end
            cu_pkg::S_ERR: begin
                if (w_free) begin
                    n_state = cu_pkg::S_IDLE;
                end
            end
            default: n_state = cu_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_phase = r_phase;
        n_m     = r_m;
        n_n     = r_n;
        n_b     = r_b;
        n_k     = r_k;
        n_j     = r_j;
        n_a     = r_a;
        n_left  = r_left;
        n_mult  = r_mult;
        n_dvsr  = r_dvsr;
        n_rank  = r_rank;
        n_acc   = r_acc;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_ov    = r_ov && !o_out.ready;
        n_elem  = r_elem;
        n_last  = r_last;
        n_bad   = r_bad;
        case (r_state)
            cu_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_m     = i_job.m;
                    n_n     = i_job.n;
                    n_rank  = i_job.rank;
                    n_b     = w_nb;
                    n_k     = SW'(1);
                    n_acc   = VW'(1);
                    n_phase = cu_pkg::PH_BIN;
                    // binomial step: acc * (m - b + k) / k
                    n_mult  = i_job.m - w_nb + SW'(1);
                    n_dvsr  = SW'(1);
                end
            end
            cu_pkg::S_CHECK: begin
                // first count C(m-1, n-1) = C(m, n) * n / m
                n_phase = cu_pkg::PH_FIRST;
                n_mult  = r_n;
                n_dvsr  = r_m;
                n_j     = '0;
                n_a     = r_m - SW'(1);
                n_left  = r_n;
            end
            cu_pkg::S_MUL: begin
                n_quo = VW'(r_acc * r_mult);
                n_rem = '0;
                n_cnt = '0;
            end
            cu_pkg::S_DIV: begin
                // restoring divide, one quotient bit a cycle
                n_cnt = r_cnt + 1'b1;
                if (w_trial >= {1'b0, r_dvsr}) begin
                    n_rem = w_trial - {1'b0, r_dvsr};
                    n_quo = {r_quo[VW-2:0], 1'b1};
                end else begin
                    n_rem = w_trial;
                    n_quo = {r_quo[VW-2:0], 1'b0};
                end
                if (w_div_end) begin
                    n_acc = n_quo;
                    if (r_phase == cu_pkg::PH_BIN) begin
                        n_k    = r_k + SW'(1);
                        n_mult = r_m - r_b + r_k + SW'(1);
                        n_dvsr = r_k + SW'(1);
                    end else begin
                        n_phase = cu_pkg::PH_WALK;
                    end
                end
            end
            cu_pkg::S_WALK: begin
                if (!w_take) begin
                    // skip element: C(a-1, b) = C(a, b) * (a - b) / a
                    n_rank = r_rank - r_acc[cu_pkg::RANK_W-1:0];
                    n_mult = r_a - (r_left - SW'(1));
                    n_dvsr = r_a;
                    n_a    = r_a - SW'(1);
                    n_j    = r_j + SW'(1);
                end else if (w_free) begin
                    n_ov   = 1'b1;
                    n_elem = r_j[cu_pkg::ELEM_W-1:0];
                    n_last = (r_left == SW'(1));
                    n_bad  = 1'b0;
                    // take element: C(a-1, b-1) = C(a, b) * b / a
                    n_left = r_left - SW'(1);
                    n_mult = r_left - SW'(1);
                    n_dvsr = r_a;
                    n_a    = r_a - SW'(1);
                    n_j    = r_j + SW'(1);
                end
            end
            cu_pkg::S_ERR: begin
                if (w_free) begin
                    n_ov   = 1'b1;
                    n_elem = '0;
                    n_last = 1'b1;
                    n_bad  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cu_pkg::S_IDLE;
            r_phase <= cu_pkg::PH_BIN;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_ov    <= n_ov;
        end
        r_m    <= n_m;
        r_n    <= n_n;
        r_b    <= n_b;
        r_k    <= n_k;
        r_j    <= n_j;
        r_a    <= n_a;
        r_left <= n_left;
        r_mult <= n_mult;
        r_dvsr <= n_dvsr;
        r_rank <= n_rank;
        r_acc  <= n_acc;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_elem <= n_elem;
        r_last <= n_last;
        r_bad  <= n_bad;
    end
endmodule

FILE: sv/combination_unrank.sv
// top level: lexicographic combination unranking
// operation: a bad-size item goes straight to the error output; otherwise the back works out the
// count in binomial steps (each one multiply then a serial divide, up to 16 steps), a rank check,
// the first count, then up to MAX_SET element steps
// throughput: one item at a time in the back; the serial divider sets the pace
// reset: synchronous active low, empties the queue and drops any pending output item
`timescale 1ns / 1ps
module combination_unrank #(
    parameter int MAX_SET = cu_pkg::MAX_SET_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cu_in_if.sink    i_in,
    cu_out_if.source o_out
);
    // front stage to queue
    logic         w_f_valid;
    logic         w_f_ready;
    cu_pkg::t_job w_f_job;
    // queue to back engine
    logic         w_q_valid;
    logic         w_q_ready;
    cu_pkg::t_job w_q_job;

    // front: registers the item and flags size errors
    cu_front #(
        .MAX_SET (MAX_SET)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (w_f_valid),
        .o_job   (w_f_job),
        .i_ready (w_f_ready)
    );

    // decoupling queue so the front can keep taking items during a long walk until the queue fills
    cu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .i_job   (w_f_job),
        .o_ready (w_f_ready),
        .o_valid (w_q_valid),
        .o_job   (w_q_job),
        .i_ready (w_q_ready)
    );

    // back: binomial count by multiply then exact divide, rank check,
    // then the element walk with the count updated each step
    cu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_job   (w_q_job),
        .o_ready (w_q_ready),
        .o_out   (o_out)
    );
endmodule

FILE: sv/cu_checker.sv
// port checks for the combination unrank block
`timescale 1ns / 1ps
module cu_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [cu_pkg::ELEM_W-1:0] i_element,
    input logic                      i_last,
    input logic                      i_bad_args
);
    logic                      r_mid;
    logic [cu_pkg::ELEM_W-1:0] r_prev;

    // remember the last element of an unfinished item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_mid <= !i_last;
        end
        if (i_out_valid && i_out_ready) begin
            r_prev <= i_element;
        end
    end

    a_bad_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_bad_args |-> i_last && i_element == '0)
        else $error("error item malformed");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_element)
            && $stable(i_last) && $stable(i_bad_args))
        else $error("stalled output changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mid && i_out_valid |-> !i_bad_args && i_element > r_prev)
        else $error("elements not ascending");
endmodule

bind combination_unrank cu_checker u_cu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_element   (o_out.element),
    .i_last      (o_out.last),
    .i_bad_args  (o_out.bad_args)
);

FILE: verif/tb_scoreboard.sv
// scoreboard: predicts the combinations that each accepted item unranks to
`timescale 1ns / 1ps
class unrank_scoreboard;
    typedef struct packed {
        logic [cu_pkg::ELEM_W-1:0] element;
        logic                      last;
        logic                      bad_args;
    } t_pick;

    t_pick pending_picks[$];
    int    n_fail;
    int    n_checked;
    int    n_bad;

    // exact binomial count, partial products stay exact in 64 bits
    static function longint unsigned choose(longint unsigned a, longint unsigned b);
        longint unsigned r;
        longint unsigned k;
        r = 1;
        if (b > a) return 0;
        if (b > a - b) b = a - b;
        for (k = 1; k <= b; k++) r = r * (a - b + k) / k;
        return r;
    endfunction

    // append one expected result
    function void add_pick(t_pick p);
        pending_picks.insert(pending_picks.size(), p);
    endfunction

    function void note_item(logic [5:0] m, logic [5:0] n, logic [29:0] rank_in,
                            int max_set);
        longint unsigned rnk;
        longint unsigned left;
        longint unsigned c;
        t_pick p;
        rnk = rank_in;
        if (n == 0 || n > m || m > max_set || n > cu_pkg::MAX_RES ||
            rnk >= choose(m, n)) begin
            p.element = '0;
            p.last = 1'b1;
            p.bad_args = 1'b1;
            add_pick(p);
            n_bad++;
            return;
        end
        left = n;
        for (int j = 0; j < m && left > 0; j++) begin
            c = choose(m - 1 - j, left - 1);
            if (rnk < c) begin
                left--;
                p.element = j[4:0];
                p.last = (left == 0);
                p.bad_args = 1'b0;
                add_pick(p);
            end else begin
                rnk -= c;
            end
        end
    endfunction

    function void check_pick(logic [4:0] element, logic last, logic bad_args);
        t_pick want;
        n_checked++;
        if (pending_picks.size() == 0) begin
            $display("%0t: unexpected item element=%0d last=%0b bad=%0b",
                     $time, element, last, bad_args);
            n_fail++;
            return;
        end
        want = pending_picks.pop_front();
        if (want.element !== element || want.last !== last || want.bad_args !== bad_args) begin
            $display("%0t: mismatch expected element=%0d last=%0b bad=%0b, got %0d %0b %0b",
                     $time, want.element, want.last, want.bad_args,
                     element, last, bad_args);
            n_fail++;
        end
    endfunction
endclass

FILE: verif/tb.sv
// testbench top: directed and random unranking items against the scoreboard
`timescale 1ns / 1ps
module tb;
    localparam int  MAX_SET   = cu_pkg::MAX_SET_DEF;
    localparam int  N_RANDOM  = 250;
    localparam longint LIMIT  = 10_000_000;

    logic i_clk;
    logic i_rst_n;
    cu_in_if  in_ch();
    cu_out_if out_ch();

    combination_unrank #(.MAX_SET(MAX_SET)) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    unrank_scoreboard sb;
    longint cycles = 0;
    bit     stim_done;
    bit     hold_off;     // long receiver stall to back up the input queue

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // offer one item after a random gap, hold it until accepted, then note it
    task automatic send_item(logic [5:0] m, logic [5:0] n, logic [29:0] r);
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0) gap = 0;
        @(negedge i_clk);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.set_size    <= m;
        in_ch.subset_size <= n;
        in_ch.rank        <= r;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_item(m, n, r, MAX_SET);
    endtask

    // random item, mostly valid: mostly small sets since each element step is slow
    task automatic send_random();
        logic [5:0] m;
        logic [5:0] n;
        logic [29:0] r;
        longint unsigned cnt;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            // noise: any bit pattern, mostly invalid
            m = 6'($urandom);
            n = 6'($urandom);
            r = 30'($urandom);
        end else begin
            m = (pick < 4) ? 6'($urandom_range(1, 32)) : 6'($urandom_range(1, 12));
            n = 6'($urandom_range(1, m));
            cnt = sb.choose(m, n);
            if (pick == 4) r = (cnt > 30'h3fffffff) ? 30'h3fffffff : 30'(cnt);  // rank too high
            else if (cnt > 64'd1073741823) r = 30'($urandom);
            else r = 30'($urandom_range(0, 32'(cnt - 1)));
        end
        send_item(m, n, r);
    endtask

    // receiver: random stalls, plus one long hold-off
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                out_ch.ready <= 1'b0;
            end else begin
                stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
                if (stall != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                out_ch.ready <= 1'b1;
                do @(posedge i_clk); while (!out_ch.valid);
            end
        end
    end

    // result monitor at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_pick(out_ch.element, out_ch.last, out_ch.bad_args);
    end

    // the long stall runs in its own process and counts cycles
    initial begin
        @(posedge i_clk);
        while (sb == null || sb.n_checked <= 20) @(posedge i_clk);
        if (!stim_done) begin
            hold_off = 1'b1;
            repeat (6000) @(posedge i_clk);
            hold_off = 1'b0;
        end
    end

    initial begin
        int drain;
        sb = new();
        hold_off = 1'b0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.set_size = '0;
        in_ch.subset_size = '0;
        in_ch.rank = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes and each invalid-argument case
        send_item(6'd1, 6'd1, 30'd0);              // smallest valid
        send_item(6'd32, 6'd32, 30'd0);            // whole set, 32 results
        send_item(6'd32, 6'd1, 30'd31);            // last single pick
        send_item(6'd32, 6'd16, 30'd601080389);    // highest rank of biggest count
        send_item(6'd32, 6'd16, 30'd601080390);    // rank equals count
        send_item(6'd32, 6'd16, 30'd0);
        send_item(6'd5, 6'd0, 30'd0);              // n zero
        send_item(6'd4, 6'd5, 30'd0);              // n above m
        send_item(6'd33, 6'd2, 30'd0);             // m above the largest set
        send_item(6'd63, 6'd63, 30'h3fffffff);     // all ones
        send_item(6'd0, 6'd0, 30'd0);              // all zeros
        send_item(6'd10, 6'd3, 30'd119);           // last of C(10,3)
        send_item(6'd10, 6'd3, 30'd120);
        send_item(6'd31, 6'd15, 30'd300540194);    // top of C(31,15)
        send_item(6'd32, 6'd31, 30'd5);
        send_item(6'd2, 6'd1, 30'h2aaaaaaa);
        send_item(6'd21, 6'd42, 30'h15555555);
        send_item(6'd6, 6'd3, 30'd7);

        for (int i = 0; i < N_RANDOM; i++) send_random();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;

        while (sb.pending_picks.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 3000) begin
            @(posedge i_clk);
            drain++;
        end

        $display("covered %0d results (%0d bad-argument), set sizes 1..32 and noise",
                 sb.n_checked, sb.n_bad);
        if (sb.n_fail == 0 && sb.pending_picks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
